// ----- src/fpst_pkg.sv -----
`timescale 1ns / 1ps

package fpst_pkg;

  // Field widths of the item channels.
  localparam int IDX_W = 11;
  localparam int VAL_W = 32;
  localparam int SUM_W = 32;
  localparam int SIZE_W = 11;

  // The walk position needs one extra bit because stepping up can pass the size.
  localparam int POS_W = IDX_W + 1;

  localparam int IN_TDATA_W = 48;
  localparam int OUT_TDATA_W = 32;

  localparam int MAX_POSITIONS_DEF = 1024;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef logic [POS_W-1:0] pos_t;

  // Item kinds carried in tuser.
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

// ----- src/fpst_ram.sv -----
`timescale 1ns / 1ps

module fpst_ram #(
  parameter int DEPTH = fpst_pkg::MAX_POSITIONS_DEF,
  parameter int ADDR_W = $clog2(fpst_pkg::MAX_POSITIONS_DEF)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [fpst_pkg::SUM_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [fpst_pkg::SUM_W-1:0] rd_data
);
  import fpst_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/fenwick_prefix_sum_table.sv -----
`timescale 1ns / 1ps

// Binary indexed tree holding prefix sums over positions 1 to size_in_use.
// Input items arrive on in_*: tuser selects an add (0) or a prefix-sum query
// (1), tdata carries the one-based index and the signed value. Each query
// produces one item on out_* with the 32-bit wrapped prefix sum; adds produce
// nothing. size_in_use is written on cfg_* and is taken in any cycle; it
// should only change while the block is idle.
// After reset the table memory is swept to zero, one entry per cycle;
// in_tready stays low until the sweep is done. Every item walks the
// lowest-set-bit chain through a single-port-read, single-port-write
// memory with a registered read. An item is accepted in idle and then
// takes at most log2(size)+1 chain steps. A query result is held in an
// output register; the block accepts further items while it waits. If the
// receiver stalls and a second query finishes, that query is held and
// in_tready stays low until the output register frees.
module fenwick_prefix_sum_table #(
  parameter int MAX_POSITIONS = fpst_pkg::MAX_POSITIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [10:0] index, [42:11] value, [47:43] zero
  input  logic [fpst_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] kind
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] prefix_sum
  output logic [fpst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpst_pkg::SIZE_W-1:0]     cfg_data
);
  import fpst_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POSITIONS);
  localparam int SIZE_CAP = (MAX_POSITIONS > 2047) ? 2047 : MAX_POSITIONS;
  localparam logic [SIZE_W-1:0] SizeCap = SIZE_W'(SIZE_CAP);
  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(MAX_POSITIONS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              kind_r, kind_nxt;
  pos_t              pos_r, pos_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_data_r, out_data_nxt;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [SUM_W-1:0]  wr_data, rd_data;

  logic [SIZE_W-1:0] eff_size;
  logic [IDX_W-1:0]  in_index;
  logic [IDX_W-1:0]  clamp_idx;
  pos_t              low_bit, pos_up, pos_dn;
  logic [SUM_W-1:0]  acc_sum, upd_sum;
  logic              slot_free;

  // Position p lives in entry p-1.
  function automatic logic [ADDR_W-1:0] addr_of(input pos_t p);
    logic [ADDR_W+POS_W-1:0] w;
    w = {{ADDR_W{1'b0}}, p - pos_t'(1)};
    return w[ADDR_W-1:0];
  endfunction

  fpst_ram #(
    .DEPTH  (MAX_POSITIONS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    eff_size = size_r;
    if (size_r == '0) begin
      eff_size = SIZE_W'(1);
    end else if (size_r > SizeCap) begin
      eff_size = SizeCap;
    end
  end

  assign in_index = in_tdata[IDX_W-1:0];
  assign clamp_idx = (in_index > eff_size) ? eff_size : in_index;

  assign low_bit = pos_r & (~pos_r + pos_t'(1));
  assign pos_up = pos_r + low_bit;
  assign pos_dn = pos_r - low_bit;
  assign acc_sum = acc_r + rd_data;
  assign upd_sum = rd_data + val_r;
  assign slot_free = !out_valid_r || out_tready;

  assign cfg_ready = 1'b1;
  assign size_nxt = cfg_valid ? cfg_data : size_r;

  always_comb begin
    state_nxt = state_r;
    clr_addr_nxt = clr_addr_r;
    kind_nxt = kind_r;
    pos_nxt = pos_r;
    val_nxt = val_r;
    acc_nxt = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    in_tready = 1'b0;
    wr_en = 1'b0;
    wr_addr = addr_of(pos_r);
    wr_data = upd_sum;
    rd_en = 1'b0;
    rd_addr = addr_of(pos_up);

    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LastAddr) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          val_nxt = in_tdata[IDX_W+VAL_W-1:IDX_W];
          pos_nxt = {1'b0, clamp_idx};
          acc_nxt = '0;
          if (clamp_idx != '0) begin
            rd_en = 1'b1;
            rd_addr = addr_of({1'b0, clamp_idx});
            state_nxt = ST_WALK;
          end else if (in_tuser == KIND_QUERY) begin
            // Empty prefix: the result is zero.
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_WALK: begin
        if (kind_r == KIND_ADD) begin
          wr_en = 1'b1;
          pos_nxt = pos_up;
          if (pos_up <= {1'b0, eff_size}) begin
            rd_en = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          acc_nxt = acc_sum;
          pos_nxt = pos_dn;
          if (pos_dn != '0) begin
            rd_en = 1'b1;
            rd_addr = addr_of(pos_dn);
          end else if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt = acc_sum;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = acc_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      size_r <= SIZE_RESET;
      clr_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r <= size_nxt;
      clr_addr_r <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    acc_r <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

// ----- src/fpst_checker.sv -----
`timescale 1ns / 1ps

module fpst_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fpst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_ready
);
  import fpst_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its sum.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result item changed while stalled");

  // Reset starts the clearing sweep: no input taken and no result shown.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block not quiet after reset");

  // A query always occupies the block for at least the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_QUERY |=> !in_tready)
    else $error("query accepted back to back");

  // The register port never pushes back.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port stalled");

endmodule

bind fenwick_prefix_sum_table fpst_checker u_fpst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
